// File: rtl/core/rce_pkg.sv
`default_nettype none
package rce_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned LINE_W = 10;
  localparam int unsigned TGT_W  = 11;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned UPC_W  = 3;
  localparam int unsigned CNT_W  = 5;

  localparam int unsigned PROGRAM_LINES = 1024;

  localparam logic [3:0] OP_ADD    = 4'd0;
  localparam logic [3:0] OP_SUB    = 4'd1;
  localparam logic [3:0] OP_MUL    = 4'd2;
  localparam logic [3:0] OP_DIV    = 4'd3;
  localparam logic [3:0] OP_MOVE   = 4'd4;
  localparam logic [3:0] OP_CMP    = 4'd5;
  localparam logic [3:0] OP_JUMP   = 4'd6;
  localparam logic [3:0] OP_BRANCH = 4'd7;
  localparam logic [3:0] OP_HALT   = 4'd8;

  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_DIVZ  = 3'd1;
  localparam logic [STAT_W-1:0] ST_DEST  = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNREC = 3'd3;
  localparam logic [STAT_W-1:0] ST_HALT  = 3'd4;

  localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  localparam logic [CNT_W-1:0] DIV_LAST_STEP = 5'd31;

  typedef struct packed {
    logic [3:0]               operation;
    logic                     first_is_register;
    logic [IDX_W-1:0]         first_register;
    logic signed [DATA_W-1:0] first_immediate;
    logic                     second_is_register;
    logic [IDX_W-1:0]         second_register;
    logic signed [DATA_W-1:0] second_immediate;
    logic [TGT_W-1:0]         jump_target;
  } in_item_t;

  typedef struct packed {
    logic                     write_enable;
    logic [IDX_W-1:0]         written_register;
    logic signed [DATA_W-1:0] written_value;
    logic [LINE_W-1:0]        next_line;
    logic [STAT_W-1:0]        status;
    logic                     finished;
  } out_item_t;

  typedef enum logic [2:0] {
    CND_NONE,
    CND_NO_ITEM,
    CND_NO_DIV,
    CND_DIV_MORE,
    CND_OUT_BUSY
  } cond_t;

  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_IDLE  = 3'd0;
  localparam upc_t UPC_FETCH = 3'd1;
  localparam upc_t UPC_EXEC  = 3'd2;
  localparam upc_t UPC_DIV   = 3'd3;
  localparam upc_t UPC_DONE  = 3'd4;

  typedef struct packed {
    logic  latch;
    logic  load_ops;
    logic  exec;
    logic  div_step;
    logic  commit;
    cond_t cond;
    upc_t  target;
    logic  ret;
  } ctrl_t;

  typedef struct packed {
    logic item_in;
    logic div_go;
    logic div_more;
    logic out_busy;
  } flags_t;

  function automatic ctrl_t ucode_rom(input upc_t pc);
    ctrl_t w;
    w = '0;
    unique case (pc)
      UPC_IDLE: begin
        w.latch  = 1'b1;
        w.cond   = CND_NO_ITEM;
        w.target = UPC_IDLE;
      end
      UPC_FETCH: begin
        w.load_ops = 1'b1;
      end
      UPC_EXEC: begin
        w.exec   = 1'b1;
        w.cond   = CND_NO_DIV;
        w.target = UPC_DONE;
      end
      UPC_DIV: begin
        w.div_step = 1'b1;
        w.cond     = CND_DIV_MORE;
        w.target   = UPC_DIV;
      end
      UPC_DONE: begin
        w.commit = 1'b1;
        w.cond   = CND_OUT_BUSY;
        w.target = UPC_DONE;
        w.ret    = 1'b1;
      end
      default: begin
        w.ret = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/register_calculator_executor.sv
`default_nettype none
// Executes one decoded calculator instruction per input item against ten
// signed Q16.16 registers, a line counter and a halted flag.
// Input channel in_valid/in_ready/in_data carries the decoded instruction;
// result channel out_valid/out_ready/out_data carries one result item per
// input item: register write, next line, status and finished flag.
// cfg_we/cfg_wdata write last_line; the user must write it only while the
// block is idle, which the block itself does not enforce. An item steps
// from idle through fetch and execute to the commit step; a divide by a
// nonzero divisor whose quotient fits, on a block not halted, runs the
// microcode divide loop in between, one restoring quotient bit per cycle in
// a dedicated subtractor. in_ready rises again in the cycle out_valid rises,
// so no new item is taken until the last one's result is committed.
// Reset clears all registers to zero, the line counter, the halted flag and
// last_line, holds in_ready low and sends the sequencer to its idle step.
// A stalled result holds in the output register; the next item may be taken
// meanwhile, and its result waits in the commit step until the output frees.
module register_calculator_executor #(
  parameter int REGISTER_COUNT = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire rce_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output rce_pkg::out_item_t              out_data,
  input  wire logic                       cfg_we,
  input  wire logic [rce_pkg::LINE_W-1:0] cfg_wdata
);
  import rce_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;

  rce_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  rce_dp #(
    .REGISTER_COUNT (REGISTER_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .flags     (flags),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  assign in_ready = ctrl.latch && rst_n;

endmodule
`default_nettype wire

// File: rtl/core/rce_ram.sv
`default_nettype none
module rce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// File: rtl/core/rce_seq.sv
`default_nettype none
module rce_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rce_pkg::flags_t flags,
  output rce_pkg::ctrl_t      ctrl
);
  import rce_pkg::*;

  upc_t pc_r;
  upc_t pc_nxt;
  logic take;

  always_comb begin
    ctrl = ucode_rom(pc_r);
    unique case (ctrl.cond)
      CND_NONE:     take = 1'b0;
      CND_NO_ITEM:  take = !flags.item_in;
      CND_NO_DIV:   take = !flags.div_go;
      CND_DIV_MORE: take = flags.div_more;
      CND_OUT_BUSY: take = flags.out_busy;
      default:      take = 1'b0;
    endcase
    if (take) begin
      pc_nxt = ctrl.target;
    end else if (ctrl.ret) begin
      pc_nxt = UPC_IDLE;
    end else begin
      pc_nxt = upc_t'(pc_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= UPC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/rce_dp.sv
`default_nettype none
module rce_dp #(
  parameter int REGISTER_COUNT = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rce_pkg::ctrl_t                ctrl,
  output rce_pkg::flags_t                    flags,
  input  wire logic                          in_valid,
  input  wire rce_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output rce_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [rce_pkg::LINE_W-1:0]    cfg_wdata
);
  import rce_pkg::*;

  localparam int RF_AW    = $clog2(REGISTER_COUNT);
  localparam int RF_DEPTH = 1 << RF_AW;

  in_item_t                 in_r;
  logic signed [DATA_W-1:0] a_r, b_r;
  logic signed [2*DATA_W-1:0] prod_r;
  logic [DATA_W-1:0]        rem_r, quo_r, dvs_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     neg_r, dovf_r;
  logic [RF_DEPTH-1:0]      rf_vld_r;
  logic                     r0_one_r;
  logic [TGT_W-1:0]         line_r;
  logic                     halted_r;
  logic [LINE_W-1:0]        last_line_r;
  out_item_t                out_r;
  logic                     out_valid_r;

  logic [DATA_W-1:0]        rd_a, rd_b;
  logic                     a_in_rng, b_in_rng;
  logic signed [DATA_W-1:0] a_sel, b_sel;
  logic [DATA_W-1:0]        mag_a, mag_b;
  logic                     div_ovf, div_go;
  logic [DATA_W:0]          div_t, div_d;
  logic                     div_ge;
  logic signed [DATA_W:0]   sum_w, diff_w;
  logic signed [2*DATA_W-1:0] prod_sh;
  logic signed [DATA_W-1:0] sum_sat, diff_sat, mul_sat, div_val;
  logic [TGT_W-1:0]         line_inc, tgt_line, next_w, next_clamp;
  logic                     res_we, halt_op, fin;
  logic [IDX_W-1:0]         res_reg;
  logic signed [DATA_W-1:0] res_val;
  logic [STAT_W-1:0]        res_st;
  logic                     out_busy, commit_go, rf_we;

  rce_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RF_DEPTH)
  ) u_rf (
    .clk     (clk),
    .we      (rf_we),
    .waddr   (res_reg[RF_AW-1:0]),
    .wdata   (res_val),
    .raddr_a (in_data.first_register[RF_AW-1:0]),
    .raddr_b (in_data.second_register[RF_AW-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_comb begin
    a_in_rng = 32'(in_r.first_register) < 32'(REGISTER_COUNT);
    b_in_rng = 32'(in_r.second_register) < 32'(REGISTER_COUNT);
    a_sel = in_r.first_immediate;
    b_sel = in_r.second_immediate;
    if (in_r.first_is_register) begin
      a_sel = (a_in_rng && rf_vld_r[in_r.first_register[RF_AW-1:0]]) ? rd_a : '0;
    end
    if (in_r.second_is_register) begin
      b_sel = (b_in_rng && rf_vld_r[in_r.second_register[RF_AW-1:0]]) ? rd_b : '0;
    end

    mag_a   = a_r[DATA_W-1] ? (~a_r + 32'd1) : a_r;
    mag_b   = b_r[DATA_W-1] ? (~b_r + 32'd1) : b_r;
    div_ovf = {16'b0, mag_a[DATA_W-1:16]} >= mag_b;
    div_go  = (in_r.operation == OP_DIV) && !halted_r && (b_r != '0) && !div_ovf;

    div_t  = {rem_r, quo_r[DATA_W-1]};
    div_d  = {1'b0, dvs_r};
    div_ge = div_t >= div_d;
  end

  always_comb begin
    sum_w  = {a_r[DATA_W-1], a_r} + {b_r[DATA_W-1], b_r};
    diff_w = {a_r[DATA_W-1], a_r} - {b_r[DATA_W-1], b_r};
    if (sum_w[DATA_W] != sum_w[DATA_W-1]) begin
      sum_sat = sum_w[DATA_W] ? SAT_MIN : SAT_MAX;
    end else begin
      sum_sat = sum_w[DATA_W-1:0];
    end
    if (diff_w[DATA_W] != diff_w[DATA_W-1]) begin
      diff_sat = diff_w[DATA_W] ? SAT_MIN : SAT_MAX;
    end else begin
      diff_sat = diff_w[DATA_W-1:0];
    end

    prod_sh = prod_r >>> 16;
    if ((&prod_sh[2*DATA_W-1:DATA_W-1]) || !(|prod_sh[2*DATA_W-1:DATA_W-1])) begin
      mul_sat = prod_sh[DATA_W-1:0];
    end else begin
      mul_sat = prod_sh[2*DATA_W-1] ? SAT_MIN : SAT_MAX;
    end

    if (neg_r) begin
      div_val = (dovf_r || quo_r[DATA_W-1]) ? SAT_MIN : (~quo_r + 32'd1);
    end else begin
      div_val = (dovf_r || quo_r[DATA_W-1]) ? SAT_MAX : quo_r;
    end

    line_inc = line_r + 11'd1;
    tgt_line = (in_r.jump_target == '0) ? '0 : (in_r.jump_target - 11'd1);

    res_we  = 1'b0;
    res_reg = '0;
    res_val = '0;
    res_st  = ST_OK;
    next_w  = line_inc;
    halt_op = 1'b0;
    if (halted_r) begin
      res_st = ST_HALT;
      next_w = line_r;
    end else begin
      unique case (in_r.operation)
        OP_ADD: begin
          res_we  = 1'b1;
          res_val = sum_sat;
        end
        OP_SUB: begin
          res_we  = 1'b1;
          res_val = diff_sat;
        end
        OP_MUL: begin
          res_we  = 1'b1;
          res_val = mul_sat;
        end
        OP_DIV: begin
          if (b_r == '0) begin
            res_st = ST_DIVZ;
          end else begin
            res_we  = 1'b1;
            res_val = div_val;
          end
        end
        OP_MOVE: begin
          if (!in_r.first_is_register || !a_in_rng) begin
            res_st = ST_DEST;
          end else begin
            res_we  = 1'b1;
            res_reg = in_r.first_register;
            res_val = b_r;
          end
        end
        OP_CMP: begin
          res_we  = 1'b1;
          res_val = (a_r >= b_r) ? '0 : Q_ONE;
        end
        OP_JUMP: begin
          next_w = tgt_line;
        end
        OP_BRANCH: begin
          if (r0_one_r) begin
            next_w = tgt_line;
          end
        end
        OP_HALT: begin
          res_st  = ST_HALT;
          next_w  = line_r;
          halt_op = 1'b1;
        end
        default: begin
          res_st = ST_UNREC;
        end
      endcase
    end

    fin = halted_r || halt_op || ({1'b0, last_line_r} < next_w);
    next_clamp = (32'(next_w) > 32'(PROGRAM_LINES - 1)) ? 11'(PROGRAM_LINES - 1) : next_w;
  end

  assign out_busy  = out_valid_r && !out_ready;
  assign commit_go = ctrl.commit && !out_busy;
  assign rf_we     = commit_go && res_we;

  assign flags.item_in  = in_valid && ctrl.latch;
  assign flags.div_go   = div_go;
  assign flags.div_more = cnt_r != '0;
  assign flags.out_busy = out_busy;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (ctrl.latch && in_valid) begin
      in_r <= in_data;
    end
    if (ctrl.load_ops) begin
      a_r <= a_sel;
      b_r <= b_sel;
    end
    if (ctrl.exec) begin
      prod_r <= 64'(a_r) * 64'(b_r);
      rem_r  <= {16'b0, mag_a[DATA_W-1:16]};
      quo_r  <= {mag_a[15:0], 16'b0};
      dvs_r  <= mag_b;
      cnt_r  <= DIV_LAST_STEP;
      neg_r  <= a_r[DATA_W-1] ^ b_r[DATA_W-1];
      dovf_r <= div_ovf;
    end else if (ctrl.div_step) begin
      rem_r <= div_ge ? 32'(div_t - div_d) : div_t[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], div_ge};
      cnt_r <= cnt_r - 5'd1;
    end
    if (commit_go) begin
      out_r.write_enable     <= res_we;
      out_r.written_register <= res_reg;
      out_r.written_value    <= res_val;
      out_r.next_line        <= next_clamp[LINE_W-1:0];
      out_r.status           <= res_st;
      out_r.finished         <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r    <= '0;
      r0_one_r    <= 1'b0;
      line_r      <= '0;
      halted_r    <= 1'b0;
      last_line_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        last_line_r <= cfg_wdata;
      end
      if (commit_go) begin
        out_valid_r <= 1'b1;
        line_r      <= next_clamp;
        halted_r    <= fin;
        if (res_we) begin
          rf_vld_r[res_reg[RF_AW-1:0]] <= 1'b1;
          if (res_reg == '0) begin
            r0_one_r <= res_val == Q_ONE;
          end
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/rce_checker.sv
`default_nettype none
module rce_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire rce_pkg::out_item_t out_data
);
  import rce_pkg::*;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.write_enable && out_data.status != ST_OK))
    else $error("register written with fault status");

  a_halt_finished: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_HALT |-> out_data.finished && !out_data.write_enable)
    else $error("halt status without finished");

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.write_enable |->
      out_data.written_register == '0 && out_data.written_value == '0)
    else $error("write fields not cleared");

endmodule

bind register_calculator_executor rce_checker u_rce_checker (.*);
`default_nettype wire
